// ----- design/tsb_pkg.sv -----
// timer bank shared types, codes and constants
// used by tsb_alu, software_timer_bank, the checker and the testbench; no dependencies
`timescale 1ns / 1ps

package tsb_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_INSTALL = 3'd1;
    localparam logic [2:0] KIND_REMOVE  = 3'd2;
    localparam logic [2:0] KIND_START   = 3'd3;
    localparam logic [2:0] KIND_STOP    = 3'd4;
    localparam logic [2:0] KIND_QUERY   = 3'd5;

    // result kinds
    localparam logic [1:0] RK_EXPIRY  = 2'd0;
    localparam logic [1:0] RK_INSTALL = 2'd1;
    localparam logic [1:0] RK_ACK     = 2'd2;
    localparam logic [1:0] RK_QUERY   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_BAD_ID    = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    // constants
    localparam logic [15:0] TICK_RESET  = 16'd20;
    localparam int          MAX_RESULTS = 8;
    localparam logic [31:0] SAT_MS      = 32'hFFFF_FFFF;

    // register map: one 16-bit register, decoded on the word address bit
    localparam int               PADDR_W         = 3;
    localparam logic [PADDR_W-3:0] REG_TICK_LENGTH = '0;

    typedef enum logic
    {
        ALU_ADD_SAT,
        ALU_SUB_FLOOR
    } alu_op_t;

    typedef struct packed
    {
        logic [2:0]  kind;
        logic [3:0]  timer_id;
        logic [31:0] timeout_ms;
        logic        periodic;
    } cmd_t;

    typedef struct packed
    {
        logic [1:0]  result_kind;
        logic [2:0]  slot;
        logic [1:0]  status;
        logic [31:0] remaining_ms;
        logic        running;
        logic        last;
    } rsp_t;

endpackage

// ----- design/software_timer_bank.sv -----
// top level of the software timer bank: slot state, sequencer, apb register
// depends on tsb_pkg and tsb_alu
`timescale 1ns / 1ps

// A bank of NUM_SLOTS timer slots driven by command transactions (tick, install, remove,
// start, stop, query) and answering with response transactions. One command is taken at a
// time: a tick walks the slots one per cycle through a single shared 32-bit adder and
// comparator, pausing only while an expiry waits for the response register to empty, and
// cmd_ready returns after the walk and its end step. Install, remove, start, stop and
// query answer once the response register is free and then return to idle; the unused
// kinds 6 and 7 are dropped with no response. Expiries come out in slot order, at most 8
// per tick, with last set on the final one; a tick without expiry gives no response. A
// response register sits on the output, so a new command is taken while an answer still
// waits. tick_length_ms is the one apb register at byte address 0 (reset 20); write it
// only while the bank is idle.
module software_timer_bank
    import tsb_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    // apb register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_TICK,
        S_TICK_END,
        S_CMD
    } state_t;

    // sequencer registers
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [2:0]       hold_slot_reg, hold_slot_next;
    cmd_t             cmd_reg, cmd_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    // slot state
    logic             alloc_reg   [NUM_SLOTS];
    logic             per_reg     [NUM_SLOTS];
    logic [31:0]      tmo_reg     [NUM_SLOTS];
    logic [31:0]      ela_reg     [NUM_SLOTS];
    logic [15:0]      tick_len_reg;

    // slot write port
    logic [IDX_W-1:0] wr_idx;
    logic             alloc_we, alloc_wdata;
    logic             per_we, per_wdata;
    logic             tmo_we;
    logic [31:0]      tmo_wdata;
    logic             ela_we;
    logic [31:0]      ela_wdata;

    // read side and shared unit
    logic [IDX_W-1:0] rd_idx;
    logic             rd_alloc, rd_per;
    logic [31:0]      rd_tmo, rd_ela;
    alu_op_t          alu_op;
    logic [31:0]      alu_a, alu_b, alu_res;
    logic             alu_ge;

    logic             id_ok;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             out_free;
    logic             armed, expire, report, stall;
    logic             cfg_wr;

    // ---------------------------------------------------------------------------------
    // apb register
    // ---------------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_TICK_LENGTH);
    assign prdata = (paddr[PADDR_W-1:2] == REG_TICK_LENGTH) ? {16'd0, tick_len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len_reg <= TICK_RESET;
        end
        else if (cfg_wr)
        begin
            tick_len_reg <= pwdata[15:0];
        end
    end

    // ---------------------------------------------------------------------------------
    // slot read, shared unit and lowest free slot
    // ---------------------------------------------------------------------------------
    // the addressed id may be beyond the bank; id_ok gates every slot access made with it
    assign id_ok  = ({1'b0, cmd_reg.timer_id} < 5'(NUM_SLOTS));
    assign rd_idx = (state_reg == S_TICK) ? idx_reg : cmd_reg.timer_id[IDX_W-1:0];

    assign rd_alloc = alloc_reg[rd_idx];
    assign rd_per   = per_reg[rd_idx];
    assign rd_tmo   = tmo_reg[rd_idx];
    assign rd_ela   = ela_reg[rd_idx];

    // tick: elapsed + tick length, saturating, compared with the timeout
    // query: timeout - elapsed, floored at zero
    assign alu_op = (state_reg == S_TICK) ? ALU_ADD_SAT : ALU_SUB_FLOOR;
    assign alu_a  = (state_reg == S_TICK) ? rd_ela : rd_tmo;
    assign alu_b  = (state_reg == S_TICK) ? {16'd0, tick_len_reg} : rd_ela;

    tsb_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .c   (rd_tmo),
        .res (alu_res),
        .ge  (alu_ge)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------------------
    assign out_free = !rsp_valid_reg || rsp_ready;

    // tick walk: an expiry is held until the next one, so last can mark the final one
    assign armed  = rd_alloc && (rd_tmo != '0);
    assign expire = armed && alu_ge;
    assign report = expire && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign stall  = report && hold_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        cmd_next        = cmd_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;

        wr_idx      = rd_idx;
        alloc_we    = 1'b0;
        alloc_wdata = 1'b0;
        per_we      = 1'b0;
        per_wdata   = 1'b0;
        tmo_we      = 1'b0;
        tmo_wdata   = '0;
        ela_we      = 1'b0;
        ela_wdata   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    if (cmd.kind == KIND_TICK)
                    begin
                        state_next      = S_TICK;
                        idx_next        = '0;
                        cnt_next        = '0;
                        hold_valid_next = 1'b0;
                    end
                    else if (cmd.kind inside {[KIND_INSTALL:KIND_QUERY]})
                    begin
                        state_next = S_CMD;
                    end
                end
            end

            S_TICK:
            begin
                if (!stall)
                begin
                    if (armed)
                    begin
                        ela_we    = 1'b1;
                        ela_wdata = (expire && rd_per) ? '0 : alu_res;
                        if (expire && !rd_per)
                        begin
                            tmo_we = 1'b1;
                        end
                    end
                    if (report)
                    begin
                        if (hold_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{RK_EXPIRY, hold_slot_reg, ST_OK, 32'd0,
                                               1'b0, 1'b0};
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = 3'(idx_reg);
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_TICK_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_TICK_END:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = '{RK_EXPIRY, hold_slot_reg, ST_OK, 32'd0, 1'b0, 1'b1};
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_CMD:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next         = '0;
                    rsp_next.last    = 1'b1;
                    rsp_next.slot    = cmd_reg.timer_id[2:0];
                    rsp_next.status  = ST_OK;
                    rsp_next.result_kind = (cmd_reg.kind == KIND_QUERY) ? RK_QUERY : RK_ACK;
                    state_next       = S_IDLE;

                    if (cmd_reg.kind == KIND_INSTALL)
                    begin
                        rsp_next.result_kind = RK_INSTALL;
                        if (free_found)
                        begin
                            rsp_next.slot = 3'(free_idx);
                            wr_idx        = free_idx;
                            alloc_we      = 1'b1;
                            alloc_wdata   = 1'b1;
                            tmo_we        = 1'b1;
                            ela_we        = 1'b1;
                        end
                        else
                        begin
                            rsp_next.slot   = '0;
                            rsp_next.status = ST_NO_FREE;
                        end
                    end
                    else if (!id_ok)
                    begin
                        rsp_next.status = ST_BAD_ID;
                    end
                    else
                    begin
                        case (cmd_reg.kind)
                            KIND_REMOVE:
                            begin
                                alloc_we = 1'b1;
                            end
                            KIND_START:
                            begin
                                if (!rd_alloc)
                                begin
                                    rsp_next.status = ST_NOT_ALLOC;
                                end
                                else
                                begin
                                    tmo_we    = 1'b1;
                                    tmo_wdata = cmd_reg.timeout_ms;
                                    per_we    = 1'b1;
                                    per_wdata = cmd_reg.periodic;
                                    ela_we    = 1'b1;
                                end
                            end
                            KIND_STOP:
                            begin
                                tmo_we = 1'b1;
                            end
                            KIND_QUERY:
                            begin
                                if (!rd_alloc)
                                begin
                                    rsp_next.status = ST_NOT_ALLOC;
                                end
                                else
                                begin
                                    rsp_next.remaining_ms = alu_res;
                                    rsp_next.running      = (alu_res != '0);
                                end
                            end
                            default:
                            begin
                                rsp_next.status = ST_OK;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        hold_slot_reg <= hold_slot_next;
        cmd_reg       <= cmd_next;
        rsp_reg       <= rsp_next;
    end

    // slot state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                alloc_reg[i] <= 1'b0;
                per_reg[i]   <= 1'b0;
                tmo_reg[i]   <= '0;
                ela_reg[i]   <= '0;
            end
        end
        else
        begin
            if (alloc_we)
            begin
                alloc_reg[wr_idx] <= alloc_wdata;
            end
            if (per_we)
            begin
                per_reg[wr_idx] <= per_wdata;
            end
            if (tmo_we)
            begin
                tmo_reg[wr_idx] <= tmo_wdata;
            end
            if (ela_we)
            begin
                ela_reg[wr_idx] <= ela_wdata;
            end
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------
    // never more expiries reported per tick than response places
    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("expiry count above limit");

    // no expiry is left held once the bank is idle again
    a_no_hold_idle : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !hold_valid_reg)
        else $error("expiry held while idle");

    // a tick transaction takes the bank busy on the next cycle
    a_tick_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.kind == KIND_TICK) |=> !cmd_ready)
        else $error("ready after tick accept");

    // a held expiry goes out only with last clear; the final one comes from the end step
    a_expiry_last : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK && rsp_valid_next && !(rsp_valid_reg && !rsp_ready))
            |-> !rsp_next.last)
        else $error("last set mid walk");

endmodule

// ----- design/tsb_alu.sv -----
// shared 32-bit arithmetic unit of the timer bank: saturating add or floored subtract
// plus a compare of the result against a third operand; uses tsb_pkg
`timescale 1ns / 1ps

module tsb_alu
    import tsb_pkg::*;
(
    input  alu_op_t     op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    output logic [31:0] res,
    output logic        ge
);

    logic [32:0] sum;
    logic [32:0] diff;

    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = {1'b0, a} - {1'b0, b};

    always_comb
    begin
        case (op)
            ALU_ADD_SAT:   res = sum[32] ? SAT_MS : sum[31:0];
            ALU_SUB_FLOOR: res = diff[32] ? '0 : diff[31:0];
            default:       res = '0;
        endcase
    end

    assign ge = (res >= c);

endmodule

// ----- dv/timer_bank_checker.sv -----
// response checker for the software timer bank: tracks slot state from the
// command and apb transactions it observes and compares every response
// depends on tsb_pkg
`timescale 1ns / 1ps

module timer_bank_checker
    import tsb_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  cmd_t               cmd,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 outstanding
);

    logic [15:0] tick_ms;
    logic        slot_alloc [NUM_SLOTS];
    logic        slot_repeat[NUM_SLOTS];
    logic [31:0] slot_tmo   [NUM_SLOTS];
    logic [31:0] slot_ela   [NUM_SLOTS];
    rsp_t        expected_rsp[$];

    function automatic rsp_t make_rsp(logic [1:0] rk, logic [2:0] s, logic [1:0] st,
                                      logic [31:0] rem, logic run);
        rsp_t r;
        r.result_kind  = rk;
        r.slot         = s;
        r.status       = st;
        r.remaining_ms = rem;
        r.running      = run;
        r.last         = 1'b0;
        return r;
    endfunction

    // advance the slot state for one command and queue what it should answer
    task automatic apply_cmd(input cmd_t c);
        rsp_t        outs[MAX_RESULTS];
        int          n;
        int          free_slot;
        logic [32:0] sum;
        logic [31:0] rem;
        logic [1:0]  rk;
        begin
            n = 0;
            free_slot = -1;
            rk = (c.kind == KIND_QUERY) ? RK_QUERY : RK_ACK;
            case (c.kind)
                KIND_TICK:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (slot_alloc[i] && slot_tmo[i] != 0)
                        begin
                            sum = {1'b0, slot_ela[i]} + {17'd0, tick_ms};
                            slot_ela[i] = sum[32] ? SAT_MS : sum[31:0];
                            if (slot_ela[i] >= slot_tmo[i])
                            begin
                                if (slot_repeat[i])
                                    slot_ela[i] = '0;
                                else
                                    slot_tmo[i] = '0;
                                if (n < MAX_RESULTS)
                                begin
                                    outs[n] = make_rsp(RK_EXPIRY, 3'(i), ST_OK, '0, 1'b0);
                                    n++;
                                end
                            end
                        end
                    end
                end
                KIND_INSTALL:
                begin
                    for (int i = NUM_SLOTS - 1; i >= 0; i--)
                        if (!slot_alloc[i])
                            free_slot = i;
                    if (free_slot < 0)
                        outs[0] = make_rsp(RK_INSTALL, 3'd0, ST_NO_FREE, '0, 1'b0);
                    else
                    begin
                        slot_alloc[free_slot] = 1'b1;
                        slot_tmo[free_slot]   = '0;
                        slot_ela[free_slot]   = '0;
                        outs[0] = make_rsp(RK_INSTALL, 3'(free_slot), ST_OK, '0, 1'b0);
                    end
                    n = 1;
                end
                KIND_REMOVE, KIND_START, KIND_STOP, KIND_QUERY:
                begin
                    if (c.timer_id >= NUM_SLOTS)
                        outs[0] = make_rsp(rk, c.timer_id[2:0], ST_BAD_ID, '0, 1'b0);
                    else if (c.kind == KIND_REMOVE)
                    begin
                        slot_alloc[c.timer_id] = 1'b0;
                        outs[0] = make_rsp(rk, c.timer_id[2:0], ST_OK, '0, 1'b0);
                    end
                    else if (c.kind == KIND_STOP)
                    begin
                        slot_tmo[c.timer_id] = '0;
                        outs[0] = make_rsp(rk, c.timer_id[2:0], ST_OK, '0, 1'b0);
                    end
                    else if (!slot_alloc[c.timer_id])
                        outs[0] = make_rsp(rk, c.timer_id[2:0], ST_NOT_ALLOC, '0, 1'b0);
                    else if (c.kind == KIND_START)
                    begin
                        slot_tmo[c.timer_id]    = c.timeout_ms;
                        slot_repeat[c.timer_id] = c.periodic;
                        slot_ela[c.timer_id]    = '0;
                        outs[0] = make_rsp(rk, c.timer_id[2:0], ST_OK, '0, 1'b0);
                    end
                    else
                    begin
                        rem = '0;
                        if (slot_tmo[c.timer_id] > slot_ela[c.timer_id])
                            rem = slot_tmo[c.timer_id] - slot_ela[c.timer_id];
                        outs[0] = make_rsp(rk, c.timer_id[2:0], ST_OK, rem, rem != 0);
                    end
                    n = 1;
                end
                default:
                begin
                    // unused kinds are dropped without an answer
                end
            endcase
            if (n > 0)
                outs[n - 1].last = 1'b1;
            for (int k = 0; k < n; k++)
                expected_rsp.push_back(outs[k]);
        end
    endtask

    task automatic check_rsp(input rsp_t got);
        rsp_t exp;
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with nothing expected: kind %0d slot %0d st %0d",
                             $realtime, got.result_kind, got.slot, got.status);
            end
            else
            begin
                exp = expected_rsp.pop_front();
                if (got.result_kind !== exp.result_kind || got.slot !== exp.slot ||
                    got.status !== exp.status || got.remaining_ms !== exp.remaining_ms ||
                    got.running !== exp.running || got.last !== exp.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response mismatch exp kind %0d slot %0d st %0d rem %h run %0d last %0d, got kind %0d slot %0d st %0d rem %h run %0d last %0d",
                                 $realtime, exp.result_kind, exp.slot, exp.status,
                                 exp.remaining_ms, exp.running, exp.last,
                                 got.result_kind, got.slot, got.status,
                                 got.remaining_ms, got.running, got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms = TICK_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_alloc[i]  = 1'b0;
                slot_repeat[i] = 1'b0;
                slot_tmo[i]    = '0;
                slot_ela[i]    = '0;
            end
            expected_rsp.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // a response can never belong to the command taken at the same edge
            if (rsp_valid && rsp_ready)
                check_rsp(rsp);
            if (cmd_valid && cmd_ready)
                apply_cmd(cmd);
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_TICK_LENGTH)
                tick_ms = pwdata[15:0];
            outstanding = expected_rsp.size();
        end
    end

endmodule

// ----- dv/tb_software_timer_bank.sv -----
// top of the software timer bank testbench: clock, reset, command and apb
// stimulus, response back-pressure and the verdict
// depends on tsb_pkg, software_timer_bank and timer_bank_checker
`timescale 1ns / 1ps

module tb_software_timer_bank;
    import tsb_pkg::*;

    localparam int NUM_SLOTS     = 8;
    // a tick with no expiry gives no response, so allow a full slot walk after
    // the last answer before touching the register or ending the run
    localparam int SETTLE_CYCLES = NUM_SLOTS + 12;
    localparam int HOLD_AT       = 100;   // command count that triggers the long stall
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_PER_PASS = 37;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    cmd_t               cmd       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    int          mismatches;
    int          outstanding;
    int          n_cmds    = 0;
    int          n_rsps    = 0;
    logic [15:0] cur_tick  = TICK_RESET;   // stimulus shaping only
    bit          no_idle   = 1'b0;
    bit          held_once = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    software_timer_bank #(.NUM_SLOTS(NUM_SLOTS)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    timer_bank_checker #(.NUM_SLOTS(NUM_SLOTS)) checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // transaction counters for the stall trigger and the summary
    always @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            n_cmds <= n_cmds + 1;
        if (rsp_valid && rsp_ready)
            n_rsps <= n_rsps + 1;
    end

    // response side: random back-pressure, none while no_idle is set, and one
    // long hold-off so that the output register fills and the command side stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!held_once && n_cmds >= HOLD_AT)
            begin
                held_once = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 8);
        end
    end

    function automatic cmd_t mk_cmd(logic [2:0] kind, logic [3:0] id, logic [31:0] tmo,
                                    logic per);
        cmd_t c;
        c.kind       = kind;
        c.timer_id   = id;
        c.timeout_ms = tmo;
        c.periodic   = per;
        return c;
    endfunction

    // timeouts cluster around small multiples of the tick length so that
    // expiries happen often, with zero, full-range and the top value mixed in
    function automatic logic [31:0] rand_timeout();
        logic [31:0] tmo;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 8)
            tmo = '0;
        else if (r < 20)
        begin
            tmo = $urandom;
            if (tmo > 32'hFFFF_0000)
                tmo = 32'hFFFF_0000;
        end
        else if (r < 23)
            tmo = 32'hFFFF_0000;
        else
        begin
            tmo = 32'(cur_tick) * 32'($urandom_range(1, 3));
            if ($urandom_range(0, 1) == 1)
                tmo = tmo - 32'($urandom_range(0, int'(cur_tick) - 1));
        end
        return tmo;
    endfunction

    // weighted command mix; ids mostly in range, some past the slot count
    function automatic cmd_t rand_cmd();
        logic [2:0] kind;
        logic [3:0] id;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 36)
            kind = KIND_TICK;
        else if (r < 48)
            kind = KIND_INSTALL;
        else if (r < 56)
            kind = KIND_REMOVE;
        else if (r < 76)
            kind = KIND_START;
        else if (r < 82)
            kind = KIND_STOP;
        else if (r < 97)
            kind = KIND_QUERY;
        else
            kind = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 9) == 0)
            id = 4'($urandom_range(NUM_SLOTS, 15));
        else
            id = 4'($urandom_range(0, NUM_SLOTS - 1));
        return mk_cmd(kind, id, rand_timeout(), 1'($urandom));
    endfunction

    // offer one command and hold it until the handshake; an idle gap, when
    // drawn, is inserted before valid rises so valid never drops mid-transaction
    task automatic send_cmd(input cmd_t c);
        begin
            if (!no_idle && $urandom_range(0, 99) < 8)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            cmd       <= c;
            cmd_valid <= 1'b1;
            @(posedge clk);
            while (!cmd_ready)
                @(posedge clk);
        end
    endtask

    // stop offering and wait until every expected response has come; the
    // checker updates its count at the clock edge, so sample it mid-cycle
    task automatic drain();
        begin
            cmd_valid <= 1'b0;
            do
                @(negedge clk);
            while (outstanding != 0);
            @(posedge clk);
        end
    endtask

    task automatic write_tick(input logic [15:0] v);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_TICK_LENGTH, 2'b00};
            pwdata  <= {16'($urandom), v};   // upper bits are not part of the register
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            psel     <= 1'b0;
            penable  <= 1'b0;
            pwrite   <= 1'b0;
            cur_tick  = v;
        end
    endtask

    // install up to three timers, start every slot within one tick and tick once, so every
    // allocated slot expires in the same walk
    task automatic all_expire();
        begin
            repeat (3)
                send_cmd(mk_cmd(KIND_INSTALL, 4'($urandom), $urandom, 1'($urandom)));
            for (int s = 0; s < NUM_SLOTS; s++)
                send_cmd(mk_cmd(KIND_START, 4'(s), 32'($urandom_range(1, int'(cur_tick))),
                                1'($urandom)));
            send_cmd(mk_cmd(KIND_TICK, 4'($urandom), $urandom, 1'($urandom)));
        end
    endtask

    initial
    begin
        logic [15:0] tick_val;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset tick length of 20
        // commands on free slots and identifiers past the slot count
        send_cmd(mk_cmd(KIND_QUERY,  4'd0,  32'd0, 1'b0));
        send_cmd(mk_cmd(KIND_START,  4'd0,  32'd100, 1'b0));
        send_cmd(mk_cmd(KIND_STOP,   4'd3,  32'd0, 1'b0));
        send_cmd(mk_cmd(KIND_REMOVE, 4'd5,  32'd0, 1'b0));
        send_cmd(mk_cmd(KIND_QUERY,  4'd9,  32'd0, 1'b0));
        send_cmd(mk_cmd(KIND_START,  4'd15, 32'hFFFF_FFFF, 1'b1));
        // fill every slot, then one install too many
        repeat (NUM_SLOTS + 1)
            send_cmd(mk_cmd(KIND_INSTALL, 4'd0, 32'd0, 1'b0));
        // one-shot, periodic, largest timeout, and zero timeout left disarmed
        send_cmd(mk_cmd(KIND_START, 4'd0, 32'd20, 1'b0));
        send_cmd(mk_cmd(KIND_START, 4'd1, 32'd40, 1'b1));
        send_cmd(mk_cmd(KIND_START, 4'd7, 32'hFFFF_0000, 1'b1));
        send_cmd(mk_cmd(KIND_START, 4'd2, 32'd0, 1'b1));
        send_cmd(mk_cmd(KIND_QUERY, 4'd1, 32'd0, 1'b0));
        send_cmd(mk_cmd(KIND_TICK,  4'd0, 32'd0, 1'b0));
        send_cmd(mk_cmd(KIND_TICK,  4'd0, 32'd0, 1'b0));
        // the expired one-shot reads back zero and not running
        send_cmd(mk_cmd(KIND_QUERY, 4'd0, 32'd0, 1'b0));
        // a removed slot no longer advances; this tick has no expiry at all
        send_cmd(mk_cmd(KIND_REMOVE, 4'd1, 32'd0, 1'b0));
        send_cmd(mk_cmd(KIND_TICK,   4'd0, 32'd0, 1'b0));
        // unused kinds, ignored
        send_cmd(mk_cmd(3'd6, 4'hF, 32'hFFFF_FFFF, 1'b1));
        send_cmd(mk_cmd(3'd7, 4'hA, 32'h5555_5555, 1'b0));

        // random passes at the largest, the smallest and two random tick lengths
        for (int p = 0; p < 4; p++)
        begin
            drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (p)
                0:       tick_val = 16'hFFFF;
                1:       tick_val = 16'd1;
                2:       tick_val = 16'($urandom_range(2, 65534));
                default: tick_val = 16'($urandom_range(2, 300));
            endcase
            write_tick(tick_val);
            // the third pass runs with neither side idling
            no_idle <= (p == 2);
            all_expire();
            for (int k = 0; k < RAND_PER_PASS; k++)
            begin
                // sender pause in the middle of the last pass
                if (p == 3 && k == RAND_PER_PASS / 2)
                    drain();
                send_cmd(rand_cmd());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d commands and %0d responses over five tick lengths,",
                 n_cmds, n_rsps);
        $display("with full-bank expiry, bad and free slots, and a long response stall");
        if (mismatches == 0)
            $display("PASS software_timer_bank");
        else
            $display("FAIL software_timer_bank");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL software_timer_bank");
        $finish;
    end

endmodule

// ----- files.f -----
design/tsb_pkg.sv
design/tsb_alu.sv
design/software_timer_bank.sv
dv/timer_bank_checker.sv
dv/tb_software_timer_bank.sv
